>>> sv/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types and codes for the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package plp_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned STAT_W       = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_INS_AT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_HD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_TL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_AT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_AT = 3'd5;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // per-cell action broadcast along the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } plp_ctl_t;

endpackage

`default_nettype wire

>>> sv/plp_cell.sv
// ----------------------------------------------------------------------------
// plp_cell
// One slot of the list. Takes its left neighbour on insert, its right
// neighbour on delete, the new value when the insert lands here.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                                       clk,
  input  wire plp_pkg::plp_ctl_t                    ctl,
  input  wire logic signed [plp_pkg::DATA_W-1:0]    left_i,
  input  wire logic signed [plp_pkg::DATA_W-1:0]    right_i,
  output logic signed [plp_pkg::DATA_W-1:0]         data_o,
  output logic signed [plp_pkg::DATA_W-1:0]         rd_o
);

  localparam logic [plp_pkg::CNT_W-1:0] IDX_V = plp_pkg::CNT_W'(IDX);

  logic signed [plp_pkg::DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.op == plp_pkg::CELL_INS && IDX_V > ctl.pos) begin
      data_r <= left_i;
    end else if (ctl.op == plp_pkg::CELL_INS && IDX_V == ctl.pos) begin
      data_r <= ctl.value;
    end else if (ctl.op == plp_pkg::CELL_DEL && IDX_V >= ctl.pos) begin
      data_r <= right_i;
    end
  end

  assign data_o = data_r;
  // zero unless addressed, so the row ORs together
  assign rd_o   = (IDX_V == ctl.pos) ? data_r : '0;

endmodule

`default_nettype wire

>>> sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list with insert, append, delete and read by position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell 0 being the head. Inserts
// and deletes shift all later cells by one place at the same clock edge, a
// read picks the addressed cell. The result appears in a single output
// register in the cycle after its item is accepted. A new item is taken only
// while that register is empty or its result leaves in the same cycle, so
// with a ready receiver one item goes through per cycle and a stalled output
// stalls the input. Each item yields one result with status, read value and
// the length after the command. No clearing pass after reset: slots beyond
// the length are never read.
`default_nettype none

module positional_list_store #(
  parameter int unsigned CAPACITY = plp_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // command[2:0], position[10:3], value[42:11], zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // status[1:0], read_value[33:2], length[41:34], zero
);

  localparam int unsigned CNT_W = plp_pkg::CNT_W;
  localparam int unsigned DW    = plp_pkg::DATA_W;
  localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

  logic [plp_pkg::CMD_W-1:0] cmd;
  logic [CNT_W-1:0]          pos;
  logic signed [DW-1:0]      val;
  logic                      in_acc;

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       out_valid_r;
  logic [plp_pkg::STAT_W-1:0] status_r, status_nxt;
  logic signed [DW-1:0]       rdval_r, rdval_nxt;
  logic [CNT_W-1:0]           len_r;

  plp_pkg::cell_op_t op_nxt;
  logic [CNT_W-1:0]  cpos;
  plp_pkg::plp_ctl_t ctl;

  logic signed [DW-1:0] data_w [CAPACITY];
  logic signed [DW-1:0] rd_w   [CAPACITY];
  logic signed [DW-1:0] rd_any;

  assign cmd = in_tdata[2:0];
  assign pos = in_tdata[10:3];
  assign val = in_tdata[42:11];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  always_comb begin
    status_nxt = plp_pkg::ST_OK;
    rdval_nxt  = '0;
    count_nxt  = count_r;
    op_nxt     = plp_pkg::CELL_HOLD;
    cpos       = pos;
    case (cmd)
      plp_pkg::CMD_INS_AT: begin
        if (pos > count_r) begin
          status_nxt = plp_pkg::ST_RANGE;
        end else if (count_r >= CAP_V) begin
          status_nxt = plp_pkg::ST_FULL;
        end else begin
          op_nxt    = plp_pkg::CELL_INS;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      plp_pkg::CMD_APPEND: begin
        cpos = count_r;
        if (count_r >= CAP_V) begin
          status_nxt = plp_pkg::ST_FULL;
        end else begin
          op_nxt    = plp_pkg::CELL_INS;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      plp_pkg::CMD_DEL_HD: begin
        cpos = '0;
        if (count_r == '0) begin
          status_nxt = plp_pkg::ST_EMPTY;
        end else begin
          op_nxt    = plp_pkg::CELL_DEL;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      plp_pkg::CMD_DEL_TL: begin
        if (count_r == '0) begin
          status_nxt = plp_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      plp_pkg::CMD_DEL_AT: begin
        if (count_r == '0) begin
          status_nxt = plp_pkg::ST_EMPTY;
        end else if (pos >= count_r) begin
          status_nxt = plp_pkg::ST_RANGE;
        end else begin
          op_nxt    = plp_pkg::CELL_DEL;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      plp_pkg::CMD_READ_AT: begin
        if (pos >= count_r) begin
          status_nxt = plp_pkg::ST_RANGE;
        end else begin
          rdval_nxt = rd_any;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.op    = in_acc ? op_nxt : plp_pkg::CELL_HOLD;
  assign ctl.pos   = cpos;
  assign ctl.value = val;

  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic signed [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = data_w[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_tail
      assign right_w = data_w[g];
    end else begin : g_nt
      assign right_w = data_w[g+1];
    end
    plp_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
      len_r    <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, len_r, rdval_r, status_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V) else $error("length above capacity");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != plp_pkg::ST_OK |-> rdval_r == '0)
    else $error("read value not zero on failed command");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == plp_pkg::ST_FULL |-> len_r == CAP_V)
    else $error("full status with room left");

  a_acc_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r && len_r == count_r)
    else $error("result not presented after accept");

endmodule

`default_nettype wire
